@@ sv/arhp_pkg.sv @@
// shared types and constants of the ascii response hex field parser
package arhp_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] ST_VALUE   = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [1:0] CFG_FIELD_LEN    = 2'd1;
    localparam logic [1:0] CFG_RESP_TIMEOUT = 2'd2;

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_STOP   = 3'd5;

    localparam logic [7:0] CHAR_CR = 8'h0d;

    localparam logic [7:0]  START_OFFSET_RST = 8'd1;
    localparam logic [3:0]  FIELD_LEN_RST    = 4'd4;
    localparam logic [15:0] RESP_TIMEOUT_RST = 16'd2000;
    localparam logic [2:0]  LATE_LIMIT       = 3'd3;

    localparam int CFG_DW = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  field_index;
        logic [31:0] field_value;
        logic        last;
    } t_result;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    typedef struct packed {
        logic room2;
    } t_fifo_stat;

endpackage

@@ sv/arhp_if.sv @@
// request and result channel interfaces
interface arhp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface arhp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  field_index;
    logic [31:0] field_value;
    logic        last;

    modport source (output valid, output status, output field_index, output field_value,
                    output last, input ready);
    modport sink   (input valid, input status, input field_index, input field_value,
                    input last, output ready);
endinterface

@@ sv/arhp_rsp_fifo.sv @@
// four entry result queue taking up to two results per cycle
module arhp_rsp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arhp_pkg::t_push     i_push,
    input  arhp_pkg::t_result   i_res0,
    input  arhp_pkg::t_result   i_res1,
    output arhp_pkg::t_fifo_stat o_stat,
    output logic                o_valid,
    output arhp_pkg::t_result   o_head,
    input  logic                i_pop
);

    arhp_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [1:0] w_push_cnt;
    logic       w_pop;

    assign w_pop      = i_pop && (r_count != 3'd0);
    assign w_push_cnt = {1'b0, i_push.push0} + {1'b0, i_push.push1};
    assign o_valid    = (r_count != 3'd0);
    assign o_head     = r_mem[r_rd_ptr];
    assign o_stat.room2 = (r_count <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + w_push_cnt;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {1'b0, w_push_cnt} - {2'b00, w_pop};
        end
    end

endmodule

@@ sv/ascii_response_hex_field_parser.sv @@
// One request is taken per clock cycle into an input register and handled there: a start,
// a received byte or a time tick. The parser state updates in the same cycle as the zero,
// one or two results it causes enter a four entry result queue, so a result reaches the
// output through the input register and then the result queue. A request waits in the
// input register only while the queue has fewer than two free entries, which happens only
// when the result side stalls; with the result side ready the block takes one request
// every cycle.
module ascii_response_hex_field_parser #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [arhp_pkg::CFG_DW-1:0]   i_cfg_data,
    arhp_req_if.sink                      i_req,
    arhp_rsp_if.source                    o_rsp
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] POS_LAST = PW'(BUFFER_BYTES - 1);

    // configuration
    logic [7:0]  r_start_offset;
    logic [3:0]  r_field_len;
    logic [15:0] r_resp_timeout;

    // input register
    logic       r_in_valid;
    logic [1:0] r_action;
    logic [7:0] r_byte;

    // response state
    logic          r_receiving, n_receiving;
    logic [15:0]   r_elapsed, n_elapsed;
    logic [2:0]    r_late, n_late;
    logic [PW-1:0] r_pos, n_pos;
    logic [3:0]    r_chars, n_chars;
    logic [2:0]    r_phase, n_phase;
    logic          r_neg, n_neg;
    logic [31:0]   r_accum, n_accum;
    logic [31:0]   r_pend_val, n_pend_val;
    logic          r_pend_valid, n_pend_valid;
    logic [7:0]    r_next_idx, n_next_idx;

    logic                 w_proc;
    arhp_pkg::t_push      w_push;
    arhp_pkg::t_result    w_res0, w_res1;
    arhp_pkg::t_fifo_stat w_fstat;
    arhp_pkg::t_result    w_head;
    logic                 w_out_valid;

    // byte decode
    logic        w_is_hex, w_is_space;
    logic [3:0]  w_digit;
    logic [2:0]  f_phase;
    logic        f_neg;
    logic [31:0] f_accum;
    logic [3:0]  w_eff_len;
    logic [3:0]  w_chars_inc;
    logic [31:0] w_chunk_now;
    logic [15:0] w_el_inc;

    assign w_proc      = r_in_valid && w_fstat.room2;
    assign i_req.ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= arhp_pkg::START_OFFSET_RST;
            r_field_len    <= arhp_pkg::FIELD_LEN_RST;
            r_resp_timeout <= arhp_pkg::RESP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arhp_pkg::CFG_START_OFFSET: r_start_offset <= i_cfg_data[7:0];
                arhp_pkg::CFG_FIELD_LEN:    r_field_len    <= i_cfg_data[3:0];
                arhp_pkg::CFG_RESP_TIMEOUT: r_resp_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_action <= i_req.action;
            r_byte   <= i_req.data_byte;
        end
    end

    always_comb begin
        w_is_hex = 1'b1;
        w_digit  = 4'd0;
        if (r_byte >= "0" && r_byte <= "9") begin
            w_digit = 4'(r_byte - 8'h30);
        end else if (r_byte >= "a" && r_byte <= "f") begin
            w_digit = 4'(r_byte - 8'h57);
        end else if (r_byte >= "A" && r_byte <= "F") begin
            w_digit = 4'(r_byte - 8'h37);
        end else begin
            w_is_hex = 1'b0;
        end
        w_is_space = (r_byte == " ") || (r_byte >= 8'd9 && r_byte <= 8'd13);
    end

    // strtol style digit scan, one character per call
    always_comb begin
        f_phase = r_phase;
        f_neg   = r_neg;
        f_accum = r_accum;
        unique case (r_phase)
            arhp_pkg::PH_SPACE, arhp_pkg::PH_SIGNED: begin
                if (r_phase == arhp_pkg::PH_SPACE && w_is_space) begin
                    f_phase = arhp_pkg::PH_SPACE;
                end else if (r_phase == arhp_pkg::PH_SPACE && (r_byte == "+" || r_byte == "-")) begin
                    f_neg   = (r_byte == "-");
                    f_phase = arhp_pkg::PH_SIGNED;
                end else if (r_byte == "0") begin
                    f_phase = arhp_pkg::PH_ZERO;
                end else if (w_is_hex) begin
                    f_accum = {28'd0, w_digit};
                    f_phase = arhp_pkg::PH_DIGITS;
                end else begin
                    f_phase = arhp_pkg::PH_STOP;
                end
            end
            arhp_pkg::PH_ZERO, arhp_pkg::PH_PREFIX, arhp_pkg::PH_DIGITS: begin
                if (r_phase == arhp_pkg::PH_ZERO && (r_byte == "x" || r_byte == "X")) begin
                    f_phase = arhp_pkg::PH_PREFIX;
                end else if (w_is_hex) begin
                    f_accum = {r_accum[27:0], w_digit};
                    f_phase = arhp_pkg::PH_DIGITS;
                end else begin
                    f_phase = arhp_pkg::PH_STOP;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_field_len == 4'd0) begin
            w_eff_len = 4'd1;
        end else if (r_field_len > 4'd8) begin
            w_eff_len = 4'd8;
        end else begin
            w_eff_len = r_field_len;
        end
    end

    assign w_chars_inc = r_chars + 4'd1;
    assign w_chunk_now = f_neg ? (32'd0 - f_accum) : f_accum;
    assign w_el_inc    = (r_elapsed != 16'hffff) ? (r_elapsed + 16'd1) : r_elapsed;

    always_comb begin
        n_receiving  = r_receiving;
        n_elapsed    = r_elapsed;
        n_late       = r_late;
        n_pos        = r_pos;
        n_chars      = r_chars;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_accum      = r_accum;
        n_pend_val   = r_pend_val;
        n_pend_valid = r_pend_valid;
        n_next_idx   = r_next_idx;
        w_push       = '0;
        w_res0       = '{status: arhp_pkg::ST_VALUE, field_index: r_next_idx,
                         field_value: r_pend_val, last: 1'b0};
        w_res1       = '{status: arhp_pkg::ST_VALUE, field_index: r_next_idx + 8'd1,
                         field_value: r_neg ? (32'd0 - r_accum) : r_accum, last: 1'b1};

        if (r_action == arhp_pkg::ACT_START) begin
            n_receiving  = 1'b1;
            n_elapsed    = '0;
            n_late       = '0;
            n_pos        = '0;
            n_chars      = '0;
            n_phase      = arhp_pkg::PH_SPACE;
            n_neg        = 1'b0;
            n_accum      = '0;
            n_pend_val   = '0;
            n_pend_valid = 1'b0;
            n_next_idx   = '0;
        end else if (r_receiving && r_action == arhp_pkg::ACT_TICK) begin
            n_elapsed = w_el_inc;
            if (w_el_inc >= r_resp_timeout) begin
                if (r_late >= arhp_pkg::LATE_LIMIT) begin
                    n_late      = arhp_pkg::LATE_LIMIT;
                    n_receiving = 1'b0;
                    w_push.push0 = 1'b1;
                    w_res0 = '{status: arhp_pkg::ST_TIMEOUT, field_index: 8'd0,
                               field_value: 32'd0, last: 1'b1};
                end else begin
                    n_late = r_late + 3'd1;
                end
            end
        end else if (r_receiving && r_action == arhp_pkg::ACT_BYTE
                     && r_elapsed < r_resp_timeout) begin
            if (r_byte == arhp_pkg::CHAR_CR) begin
                // end of response: flush pending full chunk, then partial chunk
                w_push.push0 = 1'b1;
                if (r_pend_valid) begin
                    w_res0.last  = (r_chars == 4'd0);
                    w_push.push1 = (r_chars != 4'd0);
                    n_next_idx   = (r_chars != 4'd0) ? (r_next_idx + 8'd2)
                                                     : (r_next_idx + 8'd1);
                end else if (r_chars != 4'd0) begin
                    w_res0     = w_res1;
                    w_res0.field_index = r_next_idx;
                    n_next_idx = r_next_idx + 8'd1;
                end else begin
                    w_res0 = '{status: arhp_pkg::ST_EMPTY, field_index: 8'd0,
                               field_value: 32'd0, last: 1'b1};
                end
                n_receiving  = 1'b0;
                n_late       = '0;
                n_pend_valid = 1'b0;
                n_chars      = '0;
                n_phase      = arhp_pkg::PH_SPACE;
                n_neg        = 1'b0;
                n_accum      = '0;
            end else if (r_pos < POS_LAST) begin
                n_pos = r_pos + PW'(1);
                if (CW'(r_pos) >= CW'(r_start_offset)) begin
                    if (r_chars == 4'd0 && r_pend_valid) begin
                        w_push.push0 = 1'b1;
                        n_pend_valid = 1'b0;
                        n_next_idx   = r_next_idx + 8'd1;
                    end
                    if (w_chars_inc >= w_eff_len) begin
                        n_pend_val   = w_chunk_now;
                        n_pend_valid = 1'b1;
                        n_chars      = '0;
                        n_phase      = arhp_pkg::PH_SPACE;
                        n_neg        = 1'b0;
                        n_accum      = '0;
                    end else begin
                        n_chars = w_chars_inc;
                        n_phase = f_phase;
                        n_neg   = f_neg;
                        n_accum = f_accum;
                    end
                end
            end
        end
        if (!w_proc) begin
            w_push = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_elapsed    <= '0;
            r_late       <= '0;
            r_pos        <= '0;
            r_chars      <= '0;
            r_phase      <= arhp_pkg::PH_SPACE;
            r_neg        <= 1'b0;
            r_accum      <= '0;
            r_pend_val   <= '0;
            r_pend_valid <= 1'b0;
            r_next_idx   <= '0;
        end else if (w_proc) begin
            r_receiving  <= n_receiving;
            r_elapsed    <= n_elapsed;
            r_late       <= n_late;
            r_pos        <= n_pos;
            r_chars      <= n_chars;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_accum      <= n_accum;
            r_pend_val   <= n_pend_val;
            r_pend_valid <= n_pend_valid;
            r_next_idx   <= n_next_idx;
        end
    end

    arhp_rsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .o_stat  (w_fstat),
        .o_valid (w_out_valid),
        .o_head  (w_head),
        .i_pop   (o_rsp.ready)
    );

    assign o_rsp.valid       = w_out_valid;
    assign o_rsp.status      = w_head.status;
    assign o_rsp.field_index = w_head.field_index;
    assign o_rsp.field_value = w_head.field_value;
    assign o_rsp.last        = w_head.last;

`ifndef NO_ASSERTIONS
    a_late_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_late <= arhp_pkg::LATE_LIMIT)
        else $error("late count above limit");

    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push0 && w_res0.status != arhp_pkg::ST_VALUE |=> !r_receiving)
        else $error("reception continues after final result");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push1 |-> w_push.push0 && !w_res0.last && w_res1.last)
        else $error("two results without proper last marking");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push0 |-> w_fstat.room2)
        else $error("result queue overrun");
`endif

endmodule

@@ bench/testbench.sv @@
// testbench of the ascii response hex field parser: predicts and checks every result
module testbench;
    import arhp_pkg::*;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         BUFFER_BYTES   = 256;
    localparam int         WATCHDOG_LIMIT = 3000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_idx;
    logic [CFG_DW-1:0]   i_cfg_data;

    arhp_req_if req_ch ();
    arhp_rsp_if rsp_ch ();

    ascii_response_hex_field_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // register copies used by the parser model
    logic [7:0]  cfg_start_offset = START_OFFSET_RST;
    logic [3:0]  cfg_field_len    = FIELD_LEN_RST;
    logic [15:0] cfg_resp_timeout = RESP_TIMEOUT_RST;

    // parser model state
    bit          rx_active   = 1'b0;
    logic [15:0] ticks_seen  = '0;
    logic [2:0]  late_ticks  = '0;
    int          rx_pos      = 0;
    int          chunk_chars = 0;
    logic [2:0]  chunk_phase = PH_SPACE;
    bit          chunk_neg   = 1'b0;
    logic [31:0] chunk_acc   = '0;
    logic [31:0] held_value  = '0;
    bit          held_valid  = 1'b0;
    logic [7:0]  next_field  = '0;

    t_result pending_results [$];

    int src_idle_pct  = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int requests_sent = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    function automatic int field_chars();
        if (cfg_field_len == 4'd0) return 1;
        if (cfg_field_len > 4'd8) return 8;
        return int'(cfg_field_len);
    endfunction

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] d);
        d = 4'd0;
        if (c >= "0" && c <= "9") begin
            d = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            d = 4'(c - "a") + 4'd10;
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            d = 4'(c - "A") + 4'd10;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_chunk();
        chunk_chars = 0;
        chunk_phase = PH_SPACE;
        chunk_neg   = 1'b0;
        chunk_acc   = '0;
    endfunction

    function automatic logic [31:0] chunk_value();
        return chunk_neg ? 32'd0 - chunk_acc : chunk_acc;
    endfunction

    function automatic void push_result(input logic [1:0] status, input logic [31:0] value,
                                        input bit last);
        t_result r;
        r.status      = status;
        r.field_index = (status == ST_VALUE) ? next_field : 8'd0;
        r.field_value = value;
        r.last        = last;
        pending_results.push_back(r);
        if (status == ST_VALUE) next_field = next_field + 8'd1;
    endfunction

    // strtol style base 16 scan, one character at a time
    function automatic void scan_hex_char(input logic [7:0] c);
        logic [3:0] d;
        bit         hx;
        logic [2:0] ph;
        hx = hex_nibble(c, d);
        ph = chunk_phase;
        if (ph == PH_SPACE) begin
            if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
            if (c == "+" || c == "-") begin
                chunk_neg   = (c == "-");
                chunk_phase = PH_SIGNED;
                return;
            end
            ph = PH_SIGNED;
        end
        if (ph == PH_SIGNED) begin
            if (c == "0") begin
                chunk_phase = PH_ZERO;
            end else if (hx) begin
                chunk_acc   = {28'd0, d};
                chunk_phase = PH_DIGITS;
            end else begin
                chunk_phase = PH_STOP;
            end
            return;
        end
        if (ph == PH_ZERO) begin
            if (c == "x" || c == "X") begin
                chunk_phase = PH_PREFIX;
                return;
            end
            ph = PH_PREFIX;
        end
        if (ph == PH_PREFIX || ph == PH_DIGITS) begin
            if (hx) begin
                chunk_acc   = {chunk_acc[27:0], d};
                chunk_phase = PH_DIGITS;
            end else begin
                chunk_phase = PH_STOP;
            end
        end
    endfunction

    function automatic void predict_request(input logic [1:0] action, input logic [7:0] c);
        int  pos;
        int  produced;
        produced = 0;
        if (action == ACT_START) begin
            rx_active  = 1'b1;
            ticks_seen = '0;
            late_ticks = '0;
            rx_pos     = 0;
            clear_chunk();
            held_value = '0;
            held_valid = 1'b0;
            next_field = '0;
            return;
        end
        if (!rx_active || action == ACT_UNUSED) return;

        if (action == ACT_TICK) begin
            if (ticks_seen != 16'hffff) ticks_seen = ticks_seen + 16'd1;
            if (ticks_seen >= cfg_resp_timeout) begin
                late_ticks = late_ticks + 3'd1;
                if (late_ticks > LATE_LIMIT) begin
                    late_ticks = LATE_LIMIT;
                    rx_active  = 1'b0;
                    push_result(ST_TIMEOUT, 32'd0, 1'b1);
                end
            end
            return;
        end

        // late bytes are dropped, carriage return included
        if (ticks_seen >= cfg_resp_timeout) return;

        if (c == CHAR_CR) begin
            if (held_valid) begin
                push_result(ST_VALUE, held_value, chunk_chars == 0);
                produced++;
            end
            if (chunk_chars > 0) begin
                push_result(ST_VALUE, chunk_value(), 1'b1);
                produced++;
            end
            if (produced == 0) push_result(ST_EMPTY, 32'd0, 1'b1);
            rx_active  = 1'b0;
            late_ticks = '0;
            held_valid = 1'b0;
            clear_chunk();
            return;
        end

        if (rx_pos >= BUFFER_BYTES - 1) return;
        pos    = rx_pos;
        rx_pos = rx_pos + 1;
        if (pos < int'(cfg_start_offset)) return;

        if (chunk_chars == 0 && held_valid) begin
            push_result(ST_VALUE, held_value, 1'b0);
            held_valid = 1'b0;
        end
        scan_hex_char(c);
        chunk_chars++;
        if (chunk_chars >= field_chars()) begin
            held_value = chunk_value();
            held_valid = 1'b1;
            clear_chunk();
        end
    endfunction

    function automatic void report_mismatch(input string what, input t_result want,
                                            input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch, %s: expected status %0d index %0d value %08h last %0d",
                     what, want.status, want.field_index, want.field_value, want.last);
            $display("    got status %0d index %0d value %08h last %0d",
                     got.status, got.field_index, got.field_value, got.last);
        end
    endfunction

    // model runs on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            predict_request(req_ch.action, req_ch.data_byte);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status      = rsp_ch.status;
            got.field_index = rsp_ch.field_index;
            got.field_value = rsp_ch.field_value;
            got.last        = rsp_ch.last;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.field_index !== want.field_index ||
                    got.field_value !== want.field_value || got.last !== want.last)
                    report_mismatch("wrong field", want, got);
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[ascii_response_hex_field_parser] ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] action, input logic [7:0] data);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= action;
        req_ch.data_byte <= data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // requests that give no result may still be in the input register
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input int offset, input int flen, input int tmo);
        logic [1:0]        idx  [3];
        logic [CFG_DW-1:0] vals [3];
        idx  = '{CFG_START_OFFSET, CFG_FIELD_LEN, CFG_RESP_TIMEOUT};
        vals = '{CFG_DW'(offset & 8'hff), CFG_DW'(flen & 4'hf), CFG_DW'(tmo & 16'hffff)};
        wait_results_done();
        for (int r = 0; r < 3; r++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[r];
            i_cfg_data <= vals[r];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_start_offset = vals[0][7:0];
        cfg_field_len    = vals[1][3:0];
        cfg_resp_timeout = vals[2][15:0];
    endtask

    function automatic logic [7:0] rand_hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("a" + k - 10);
        return 8'("A" + k - 16);
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
        return c;
    endfunction

    task automatic maybe_insert_ticks();
        int n;
        if ($urandom_range(0, 99) == 0) send_request(ACT_UNUSED, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) >= 4) return;
        if (cfg_resp_timeout <= 16'd64) n = $urandom_range(1, int'(cfg_resp_timeout) + 4);
        else n = $urandom_range(1, 3);
        repeat (n) send_request(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_chunk(input int len);
        logic [7:0] chars [$];
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                if ($urandom_range(0, 1)) chars.push_back(" ");
                case ($urandom_range(0, 2))
                    0: chars.push_back("+");
                    1: chars.push_back("-");
                    default: ;
                endcase
                chars.push_back("0");
                chars.push_back($urandom_range(0, 1) ? "x" : "X");
            end
            2: chars.push_back(rand_text_char());
            default: begin
                chars.push_back(rand_hex_char());
                chars.push_back("g");
            end
        endcase
        while (chars.size() < len) chars.push_back(rand_hex_char());
        for (int i = 0; i < len; i++) begin
            maybe_insert_ticks();
            c = chars[i];
            // occasional corrupted byte, which may end the response early
            if ($urandom_range(0, 49) == 0) c = 8'($urandom_range(0, 255));
            send_request(ACT_BYTE, c);
        end
    endtask

    task automatic send_response(input int nfields, input int partial);
        send_request(ACT_START, 8'($urandom_range(0, 255)));
        repeat (cfg_start_offset) send_request(ACT_BYTE, rand_text_char());
        repeat (nfields) send_chunk(field_chars());
        if (partial > 0) send_chunk(partial);
        if ($urandom_range(0, 19) != 0) send_request(ACT_BYTE, CHAR_CR);
    endtask

    task automatic test_idle_and_empty();
        send_request(ACT_BYTE, "5");
        send_request(ACT_TICK, 8'h00);
        send_request(ACT_START, 8'hff);
        send_request(ACT_UNUSED, "1");
        send_request(ACT_BYTE, CHAR_CR);
    endtask

    task automatic test_field_syntax();
        logic [7:0] text [$];
        text = '{"R", "-", "0", "x", "1", 8'h0b, "+", "f", "F",
                 8'h00, "z", 8'hff, "2", "0", "X", "7", "f", CHAR_CR};
        send_request(ACT_START, 8'h00);
        foreach (text[i]) send_request(ACT_BYTE, text[i]);
    endtask

    task automatic test_deadline();
        set_config(1, 4, 0);
        send_request(ACT_START, 8'h00);
        send_request(ACT_BYTE, "1");
        send_request(ACT_BYTE, CHAR_CR);
        repeat (4) send_request(ACT_TICK, 8'hff);
        send_request(ACT_BYTE, "2");
    endtask

    task automatic test_random_traffic();
        int offs  [5] = '{1, 0, 3, 2, 7};
        int lens  [5] = '{4, 1, 8, 0, 15};
        int tmos  [5] = '{2000, 65535, 40, 25, 1};
        int srcs  [5] = '{0, 47, 0, 27, 27};
        int snks  [5] = '{0, 0, 47, 27, 27};
        int first;
        for (int p = 0; p < 5; p++) begin
            set_config(offs[p], lens[p], tmos[p]);
            src_idle_pct = srcs[p];
            stall_pct    = snks[p];
            first        = requests_sent;
            while (requests_sent - first < 40) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(3, 10))
                        send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                else
                    send_response($urandom_range(0, 5), $urandom_range(0, field_chars() - 1));
            end
        end
    endtask

    // high start offset and a response longer than the buffer
    task automatic test_buffer_limits();
        set_config(250, 1, 65535);
        src_idle_pct = 0;
        stall_pct    = 0;
        send_request(ACT_START, 8'h00);
        repeat (260) send_request(ACT_BYTE, rand_hex_char());
        send_request(ACT_BYTE, CHAR_CR);
    endtask

    task automatic test_backpressure();
        set_config(0, 1, 2000);
        src_idle_pct = 0;
        stall_pct    = 0;
        hold_request = 300;
        repeat (3) begin
            send_request(ACT_START, 8'h00);
            repeat (20) send_request(ACT_BYTE, rand_hex_char());
            send_request(ACT_BYTE, CHAR_CR);
        end
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_START_OFFSET;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_START;
        req_ch.data_byte = 8'h00;
        rsp_ch.ready     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_empty();
        test_field_syntax();
        test_deadline();
        test_random_traffic();
        test_buffer_limits();
        test_backpressure();
        wait_results_done();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ascii_response_hex_field_parser] OK");
        else
            $display("[ascii_response_hex_field_parser] ERROR");
        $finish;
    end

endmodule
